FILE: sv/rig_pkg.sv
// Shared types, register codes and sequencer command codes for the reprojection inlier gate.
package rig_pkg;

	// Tally limits
	localparam int MAX_POINTS = 4096;
	localparam int TALLY_W = 13;
	localparam int TALLY_CAP = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_POSE_ROW0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POSE_ROW1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POSE_ROW2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT = 3'd7;

	// Register values after reset
	localparam logic [63:0] RST_POSE_ROW0   = 64'h0000_0000_4000_0000;
	localparam logic [63:0] RST_POSE_ROW1   = 64'h0000_0000_0000_4000;
	localparam logic [63:0] RST_POSE_ROW2   = 64'h0000_0000_0000_0100;
	localparam logic [15:0] RST_FOCAL_X     = 16'd18874;
	localparam logic [15:0] RST_FOCAL_Y     = 16'd18874;
	localparam logic [15:0] RST_CENTER_X    = 16'd8109;
	localparam logic [15:0] RST_CENTER_Y    = 16'd8357;
	localparam logic [15:0] RST_ERROR_LIMIT = 16'd96;

	// Sequencer
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = 5'd24;

	// Multiplier operand A sources
	localparam logic [2:0] OPA_ROW = 3'd0;
	localparam logic [2:0] OPA_FX  = 3'd1;
	localparam logic [2:0] OPA_FY  = 3'd2;
	localparam logic [2:0] OPA_DCX = 3'd3;
	localparam logic [2:0] OPA_DCY = 3'd4;
	localparam logic [2:0] OPA_LIM = 3'd5;
	localparam logic [2:0] OPA_HI  = 3'd6;
	localparam logic [2:0] OPA_LO  = 3'd7;

	// Multiplier operand B sources
	localparam logic [2:0] OPB_NONE  = 3'd0;
	localparam logic [2:0] OPB_WORLD = 3'd1;
	localparam logic [2:0] OPB_CX    = 3'd2;
	localparam logic [2:0] OPB_CY    = 3'd3;
	localparam logic [2:0] OPB_CZ    = 3'd4;
	localparam logic [2:0] OPB_ABSZ  = 3'd5;
	localparam logic [2:0] OPB_HI    = 3'd6;
	localparam logic [2:0] OPB_LO    = 3'd7;

	// Magnitude selected for squaring
	localparam logic [1:0] MAG_A = 2'd0;
	localparam logic [1:0] MAG_B = 2'd1;
	localparam logic [1:0] MAG_L = 2'd2;

	// Accumulator operations
	localparam logic [2:0] ACC_NONE    = 3'd0;
	localparam logic [2:0] ACC_FIRST   = 3'd1;
	localparam logic [2:0] ACC_FIRST_T = 3'd2;
	localparam logic [2:0] ACC_ADD     = 3'd3;
	localparam logic [2:0] ACC_SUB     = 3'd4;

	// Product alignment
	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_28 = 2'd1;
	localparam logic [1:0] SH_54 = 2'd2;

	// Accumulator store targets
	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_CX   = 3'd1;
	localparam logic [2:0] ST_CY   = 3'd2;
	localparam logic [2:0] ST_CZ   = 3'd3;
	localparam logic [2:0] ST_MAGA = 3'd4;
	localparam logic [2:0] ST_MAGB = 3'd5;
	localparam logic [2:0] ST_MAGL = 3'd6;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic [15:0]        meas_u;
		logic [15:0]        meas_v;
		logic [15:0]        ref_u;
		logic [15:0]        ref_v;
		logic               last_point;
	} rig_in_t;

	typedef struct packed {
		logic               is_outlier;
		logic               depth_zero;
		logic [15:0]        out_ref_u;
		logic [15:0]        out_ref_v;
		logic [15:0]        out_meas_u;
		logic [15:0]        out_meas_v;
		logic [TALLY_W-1:0] inliers_so_far;
		logic [TALLY_W-1:0] outliers_so_far;
		logic               set_done;
	} rig_out_t;

	typedef struct packed {
		logic       load;
		logic       finish;
		logic [2:0] opa;
		logic [2:0] opb;
		logic [1:0] row;
		logic [1:0] col;
		logic [1:0] mag;
		logic [2:0] acc_op;
		logic [1:0] t_row;
		logic [1:0] shift;
		logic [2:0] store;
	} rig_cmd_t;

endpackage

FILE: sv/reprojection_inlier_gate.sv
// One request is worked on at a time: a new one is taken only once the last has finished.
// The 25 sequencer steps share one 28x38 multiplier.
// The next request is taken while a finished result still waits in the output register.
// Reset: tallies clear, configuration returns to defaults, handshakes go idle; no clearing pass.
// Top level: joins the controller and the datapath.
module reprojection_inlier_gate (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rig_pkg::rig_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rig_pkg::rig_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [rig_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rig_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rig_pkg::*;

	rig_cmd_t cmd;

	// Sequence each request
	rig_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Compute, count and hold the result
	rig_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

endmodule

FILE: sv/rig_ctrl.sv
// Controller: request handshake, step sequencer and result-slot tracking.
module rig_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output rig_pkg::rig_cmd_t cmd
);
	import rig_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              slot_free;
	rig_cmd_t          step_cmd;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode the current step into multiplier, accumulator and store controls
	always_comb begin
		step_cmd = '0;
		unique case (step_q)
			5'd0: begin
				step_cmd.opa = OPA_ROW; step_cmd.opb = OPB_WORLD;
				step_cmd.row = 2'd0; step_cmd.col = 2'd0;
			end
			5'd1: begin
				step_cmd.opa = OPA_ROW; step_cmd.opb = OPB_WORLD;
				step_cmd.row = 2'd0; step_cmd.col = 2'd1;
				step_cmd.acc_op = ACC_FIRST_T; step_cmd.t_row = 2'd0;
			end
			5'd2: begin
				step_cmd.opa = OPA_ROW; step_cmd.opb = OPB_WORLD;
				step_cmd.row = 2'd0; step_cmd.col = 2'd2;
				step_cmd.acc_op = ACC_ADD;
			end
			5'd3: begin
				step_cmd.opa = OPA_ROW; step_cmd.opb = OPB_WORLD;
				step_cmd.row = 2'd1; step_cmd.col = 2'd0;
				step_cmd.acc_op = ACC_ADD;
			end
			5'd4: begin
				step_cmd.opa = OPA_ROW; step_cmd.opb = OPB_WORLD;
				step_cmd.row = 2'd1; step_cmd.col = 2'd1;
				step_cmd.acc_op = ACC_FIRST_T; step_cmd.t_row = 2'd1;
				step_cmd.store = ST_CX;
			end
			5'd5: begin
				step_cmd.opa = OPA_ROW; step_cmd.opb = OPB_WORLD;
				step_cmd.row = 2'd1; step_cmd.col = 2'd2;
				step_cmd.acc_op = ACC_ADD;
			end
			5'd6: begin
				step_cmd.opa = OPA_ROW; step_cmd.opb = OPB_WORLD;
				step_cmd.row = 2'd2; step_cmd.col = 2'd0;
				step_cmd.acc_op = ACC_ADD;
			end
			5'd7: begin
				step_cmd.opa = OPA_ROW; step_cmd.opb = OPB_WORLD;
				step_cmd.row = 2'd2; step_cmd.col = 2'd1;
				step_cmd.acc_op = ACC_FIRST_T; step_cmd.t_row = 2'd2;
				step_cmd.store = ST_CY;
			end
			5'd8: begin
				step_cmd.opa = OPA_ROW; step_cmd.opb = OPB_WORLD;
				step_cmd.row = 2'd2; step_cmd.col = 2'd2;
				step_cmd.acc_op = ACC_ADD;
			end
			5'd9: begin
				step_cmd.opa = OPA_FX; step_cmd.opb = OPB_CX;
				step_cmd.acc_op = ACC_ADD;
			end
			5'd10: begin
				step_cmd.acc_op = ACC_FIRST; step_cmd.store = ST_CZ;
			end
			5'd11: begin
				step_cmd.opa = OPA_DCX; step_cmd.opb = OPB_CZ;
			end
			5'd12: begin
				step_cmd.opa = OPA_FY; step_cmd.opb = OPB_CY;
				step_cmd.acc_op = ACC_ADD;
			end
			5'd13: begin
				step_cmd.opa = OPA_DCY; step_cmd.opb = OPB_CZ;
				step_cmd.acc_op = ACC_FIRST; step_cmd.store = ST_MAGA;
			end
			5'd14: begin
				step_cmd.opa = OPA_LIM; step_cmd.opb = OPB_ABSZ;
				step_cmd.acc_op = ACC_ADD;
			end
			5'd15: begin
				step_cmd.opa = OPA_HI; step_cmd.opb = OPB_HI; step_cmd.mag = MAG_A;
				step_cmd.acc_op = ACC_FIRST; step_cmd.store = ST_MAGB;
			end
			5'd16: begin
				step_cmd.opa = OPA_HI; step_cmd.opb = OPB_LO; step_cmd.mag = MAG_A;
				step_cmd.acc_op = ACC_FIRST; step_cmd.shift = SH_54;
				step_cmd.store = ST_MAGL;
			end
			5'd17: begin
				step_cmd.opa = OPA_LO; step_cmd.opb = OPB_LO; step_cmd.mag = MAG_A;
				step_cmd.acc_op = ACC_ADD; step_cmd.shift = SH_28;
			end
			5'd18: begin
				step_cmd.opa = OPA_HI; step_cmd.opb = OPB_HI; step_cmd.mag = MAG_B;
				step_cmd.acc_op = ACC_ADD; step_cmd.shift = SH_0;
			end
			5'd19: begin
				step_cmd.opa = OPA_HI; step_cmd.opb = OPB_LO; step_cmd.mag = MAG_B;
				step_cmd.acc_op = ACC_ADD; step_cmd.shift = SH_54;
			end
			5'd20: begin
				step_cmd.opa = OPA_LO; step_cmd.opb = OPB_LO; step_cmd.mag = MAG_B;
				step_cmd.acc_op = ACC_ADD; step_cmd.shift = SH_28;
			end
			5'd21: begin
				step_cmd.opa = OPA_HI; step_cmd.opb = OPB_HI; step_cmd.mag = MAG_L;
				step_cmd.acc_op = ACC_ADD; step_cmd.shift = SH_0;
			end
			5'd22: begin
				step_cmd.opa = OPA_HI; step_cmd.opb = OPB_LO; step_cmd.mag = MAG_L;
				step_cmd.acc_op = ACC_SUB; step_cmd.shift = SH_54;
			end
			5'd23: begin
				step_cmd.opa = OPA_LO; step_cmd.opb = OPB_LO; step_cmd.mag = MAG_L;
				step_cmd.acc_op = ACC_SUB; step_cmd.shift = SH_28;
			end
			5'd24: begin
				step_cmd.acc_op = ACC_SUB; step_cmd.shift = SH_0;
			end
			default: begin
				step_cmd = '0;
			end
		endcase
	end

	// Issue step commands only while running; add load and finish strobes
	always_comb begin
		cmd = (state_q == ST_RUN) ? step_cmd : '0;
		cmd.load   = in_valid && in_ready;
		cmd.finish = (state_q == ST_FIN) && slot_free;
	end

	// Advance the state machine and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result slot until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_RUN) && (step_q == '0))
		else $error("accepted request did not start the sequence at step zero");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= LAST_STEP))
		else $error("step counter ran past the last step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result written over one that was not yet taken");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished result not presented");

endmodule

FILE: sv/rig_dp.sv
// Datapath: configuration registers, shared multiplier, accumulator, tallies and result register.
module rig_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rig_pkg::rig_cmd_t                 cmd,
	input  rig_pkg::rig_in_t                  in_data,
	output rig_pkg::rig_out_t                 out_data,
	input  logic                              cfg_we,
	input  logic [rig_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rig_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import rig_pkg::*;

	localparam int OPA_W  = 28;
	localparam int OPB_W  = 38;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int ACC_W  = 110;
	localparam int CAM_W  = 37;
	localparam int FLR_SH = 14;
	localparam int MAG_W  = 53;
	localparam int HALF_W = 27;
	localparam int T_SH   = 22;

	// Configuration registers
	logic [63:0] pose0_q, pose1_q, pose2_q;
	logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q, limit_q;

	// Work registers
	rig_in_t                   in_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [CAM_W-1:0]   cx_q, cy_q, cz_q;
	logic                      dz_q;
	logic [MAG_W-1:0]          maga_q, magb_q, magl_q;
	logic [TALLY_W-1:0]        inl_q, outl_q;
	rig_out_t                  out_q;

	// Combinational
	logic [63:0]               row_sel, trow_sel;
	logic [15:0]               coef;
	logic signed [15:0]        tval;
	logic signed [31:0]        world_sel;
	logic signed [16:0]        dcx, dcy;
	logic [CAM_W-1:0]          absz;
	logic [MAG_W-1:0]          mag_sel;
	logic [MAG_W-HALF_W-1:0]   mag_hi;
	logic [HALF_W-1:0]         mag_lo;
	logic signed [OPA_W-1:0]   opa_v;
	logic signed [OPB_W-1:0]   opb_v;
	logic signed [ACC_W-1:0]   prod_ext, prod_sh, t_ext;
	logic [ACC_W-1:0]          acc_abs;
	logic                      outl;
	logic [TALLY_W-1:0]        inl_next, outl_next;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose0_q    <= RST_POSE_ROW0;
			pose1_q    <= RST_POSE_ROW1;
			pose2_q    <= RST_POSE_ROW2;
			focal_x_q  <= RST_FOCAL_X;
			focal_y_q  <= RST_FOCAL_Y;
			center_x_q <= RST_CENTER_X;
			center_y_q <= RST_CENTER_Y;
			limit_q    <= RST_ERROR_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_POSE_ROW0:   pose0_q    <= cfg_wdata;
				CFG_POSE_ROW1:   pose1_q    <= cfg_wdata;
				CFG_POSE_ROW2:   pose2_q    <= cfg_wdata;
				CFG_FOCAL_X:     focal_x_q  <= cfg_wdata[15:0];
				CFG_FOCAL_Y:     focal_y_q  <= cfg_wdata[15:0];
				CFG_CENTER_X:    center_x_q <= cfg_wdata[15:0];
				CFG_CENTER_Y:    center_y_q <= cfg_wdata[15:0];
				CFG_ERROR_LIMIT: limit_q    <= cfg_wdata[15:0];
			endcase
		end
	end

	// Select pose coefficient, translation and world coordinate
	always_comb begin
		unique case (cmd.row)
			2'd1:    row_sel = pose1_q;
			2'd2:    row_sel = pose2_q;
			default: row_sel = pose0_q;
		endcase
		unique case (cmd.t_row)
			2'd1:    trow_sel = pose1_q;
			2'd2:    trow_sel = pose2_q;
			default: trow_sel = pose0_q;
		endcase
		unique case (cmd.col)
			2'd1: begin
				coef      = row_sel[47:32];
				world_sel = in_q.world_y;
			end
			2'd2: begin
				coef      = row_sel[31:16];
				world_sel = in_q.world_z;
			end
			default: begin
				coef      = row_sel[63:48];
				world_sel = in_q.world_x;
			end
		endcase
		tval = trow_sel[15:0];
	end

	// Principal point offsets and magnitude halves
	assign dcx  = $signed({1'b0, center_x_q}) - $signed({1'b0, in_q.meas_u});
	assign dcy  = $signed({1'b0, center_y_q}) - $signed({1'b0, in_q.meas_v});
	assign absz = cz_q[CAM_W-1] ? (CAM_W'(0) - cz_q) : cz_q;

	always_comb begin
		unique case (cmd.mag)
			MAG_B:   mag_sel = magb_q;
			MAG_L:   mag_sel = magl_q;
			default: mag_sel = maga_q;
		endcase
	end

	assign mag_hi = mag_sel[MAG_W-1:HALF_W];
	assign mag_lo = mag_sel[HALF_W-1:0];

	// Multiplier operand A
	always_comb begin
		unique case (cmd.opa)
			OPA_ROW: opa_v = {{(OPA_W-16){coef[15]}}, coef};
			OPA_FX:  opa_v = {{(OPA_W-16){1'b0}}, focal_x_q};
			OPA_FY:  opa_v = {{(OPA_W-16){1'b0}}, focal_y_q};
			OPA_DCX: opa_v = {{(OPA_W-17){dcx[16]}}, dcx};
			OPA_DCY: opa_v = {{(OPA_W-17){dcy[16]}}, dcy};
			OPA_LIM: opa_v = {{(OPA_W-16){1'b0}}, limit_q};
			OPA_HI:  opa_v = {{(OPA_W-(MAG_W-HALF_W)){1'b0}}, mag_hi};
			OPA_LO:  opa_v = {{(OPA_W-HALF_W){1'b0}}, mag_lo};
		endcase
	end

	// Multiplier operand B
	always_comb begin
		unique case (cmd.opb)
			OPB_WORLD: opb_v = {{(OPB_W-32){world_sel[31]}}, world_sel};
			OPB_CX:    opb_v = {{(OPB_W-CAM_W){cx_q[CAM_W-1]}}, cx_q};
			OPB_CY:    opb_v = {{(OPB_W-CAM_W){cy_q[CAM_W-1]}}, cy_q};
			OPB_CZ:    opb_v = {{(OPB_W-CAM_W){cz_q[CAM_W-1]}}, cz_q};
			OPB_ABSZ:  opb_v = {{(OPB_W-CAM_W){1'b0}}, absz};
			OPB_HI:    opb_v = {{(OPB_W-(MAG_W-HALF_W)){1'b0}}, mag_hi};
			OPB_LO:    opb_v = {{(OPB_W-HALF_W){1'b0}}, mag_lo};
			OPB_NONE:  opb_v = '0;
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		prod_q <= opa_v * opb_v;
	end

	// Align product and translation for the accumulator
	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign t_ext    = {{(ACC_W-16-T_SH){tval[15]}}, tval, {T_SH{1'b0}}};

	always_comb begin
		unique case (cmd.shift)
			SH_28:   prod_sh = prod_ext <<< 28;
			SH_54:   prod_sh = prod_ext <<< 54;
			default: prod_sh = prod_ext;
		endcase
	end

	// Accumulate
	always_ff @(posedge clk) begin
		unique case (cmd.acc_op)
			ACC_FIRST:   acc_q <= prod_sh;
			ACC_FIRST_T: acc_q <= t_ext + prod_sh;
			ACC_ADD:     acc_q <= acc_q + prod_sh;
			ACC_SUB:     acc_q <= acc_q - prod_sh;
			default:     acc_q <= acc_q;
		endcase
	end

	assign acc_abs = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;

	// Store floored camera coordinates and error magnitudes
	always_ff @(posedge clk) begin
		unique case (cmd.store)
			ST_CX: cx_q <= acc_q[CAM_W+FLR_SH-1:FLR_SH];
			ST_CY: cy_q <= acc_q[CAM_W+FLR_SH-1:FLR_SH];
			ST_CZ: begin
				cz_q <= acc_q[CAM_W+FLR_SH-1:FLR_SH];
				dz_q <= (acc_q == '0);
			end
			ST_MAGA: maga_q <= acc_abs[MAG_W-1:0];
			ST_MAGB: magb_q <= acc_abs[MAG_W-1:0];
			ST_MAGL: magl_q <= acc_abs[MAG_W-1:0];
			default: begin
			end
		endcase
	end

	// Latch the accepted request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
	end

	// Decide and count: squared error sum minus squared limit is left in the accumulator
	assign outl      = dz_q || (!acc_q[ACC_W-1] && (acc_q != '0));
	assign inl_next  = (!outl && (inl_q < TALLY_W'(TALLY_CAP))) ? inl_q + 1'b1 : inl_q;
	assign outl_next = (outl && (outl_q < TALLY_W'(TALLY_CAP))) ? outl_q + 1'b1 : outl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inl_q  <= '0;
			outl_q <= '0;
		end else if (cmd.finish) begin
			inl_q  <= in_q.last_point ? '0 : inl_next;
			outl_q <= in_q.last_point ? '0 : outl_next;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.is_outlier      <= outl;
			out_q.depth_zero      <= dz_q;
			out_q.out_ref_u       <= in_q.ref_u;
			out_q.out_ref_v       <= in_q.ref_v;
			out_q.out_meas_u      <= in_q.meas_u;
			out_q.out_meas_v      <= in_q.meas_v;
			out_q.inliers_so_far  <= inl_next;
			out_q.outliers_so_far <= outl_next;
			out_q.set_done        <= in_q.last_point;
		end
	end

	assign out_data = out_q;

	a_tally_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(inl_q <= TALLY_W'(TALLY_CAP)) && (outl_q <= TALLY_W'(TALLY_CAP)))
		else $error("tally exceeded its saturation limit");

endmodule

FILE: tb/tb_reprojection_inlier_gate.sv
// Self-checking testbench for the reprojection inlier gate: directed and random matches
`timescale 1ns / 1ps

module tb_reprojection_inlier_gate;
	import rig_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	rig_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	rig_out_t              out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Shadow copy of the camera registers and the per-set tallies
	logic [63:0]        pose_rows [3];
	logic [15:0]        focal_u, focal_v, center_u, center_v, err_limit;
	logic [TALLY_W-1:0] inlier_tally = '0;
	logic [TALLY_W-1:0] outlier_tally = '0;

	rig_in_t  match_backlog [$];
	rig_out_t pending_verdicts [$];

	bit in_took = 1'b0;
	bit out_took = 1'b0;
	bit idle_on = 1'b1;
	bit drain_hold = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int accepted_count = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	reprojection_inlier_gate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Exact camera coordinate in Q.30 for one pose row
	function automatic longint cam_exact(input logic [63:0] row, input rig_in_t p);
		longint r0, r1, r2, tr, wx, wy, wz;
		r0 = $signed(row[63:48]);
		r1 = $signed(row[47:32]);
		r2 = $signed(row[31:16]);
		tr = $signed(row[15:0]);
		wx = $signed(p.world_x);
		wy = $signed(p.world_y);
		wz = $signed(p.world_z);
		return r0 * wx + r1 * wy + r2 * wz + (tr <<< 22);
	endfunction

	// Classify one match and advance the set tallies
	function automatic rig_out_t gate_match(input rig_in_t m);
		longint zx, cx, cy, cz, a, b, fu, fv, cu, cv, mu, mv, lim;
		logic [63:0]  ma, mb, ml;
		logic [127:0] err_sq, lim_sq;
		logic         dz, outl;
		rig_out_t     v;
		zx = cam_exact(pose_rows[2], m);
		dz = (zx == 0);
		cx = cam_exact(pose_rows[0], m) >>> 14;
		cy = cam_exact(pose_rows[1], m) >>> 14;
		cz = zx >>> 14;
		fu = focal_u;
		fv = focal_v;
		cu = center_u;
		cv = center_v;
		mu = m.meas_u;
		mv = m.meas_v;
		lim = err_limit;
		a = fu * cx + (cu - mu) * cz;
		b = fv * cy + (cv - mv) * cz;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		ml = lim * ((cz < 0) ? -cz : cz);
		err_sq = {64'd0, ma} * {64'd0, ma} + {64'd0, mb} * {64'd0, mb};
		lim_sq = {64'd0, ml} * {64'd0, ml};
		outl = dz || (err_sq > lim_sq);
		// saturate each tally at the cap
		if (outl) begin
			if (outlier_tally < TALLY_CAP)
				outlier_tally++;
		end else begin
			if (inlier_tally < TALLY_CAP)
				inlier_tally++;
		end
		v.is_outlier      = outl;
		v.depth_zero      = dz;
		v.out_ref_u       = m.ref_u;
		v.out_ref_v       = m.ref_v;
		v.out_meas_u      = m.meas_u;
		v.out_meas_v      = m.meas_v;
		v.inliers_so_far  = inlier_tally;
		v.outliers_so_far = outlier_tally;
		v.set_done        = m.last_point;
		if (m.last_point) begin
			inlier_tally  = '0;
			outlier_tally = '0;
		end
		return v;
	endfunction

	// Realistic pose row: near-unit diagonal, small cross terms, a few pixels of shift
	function automatic logic [63:0] pose_row_rand(input int axis);
		logic [15:0] r [3];
		for (int k = 0; k < 3; k++)
			r[k] = (k == axis) ? 16'(16384 - $urandom_range(0, 2000))
			                   : 16'($urandom_range(0, 6000) - 3000);
		return {r[0], r[1], r[2], 16'($urandom_range(0, 5120) - 2560)};
	endfunction

	// Queue one match; the reference pixel is the measured one complemented, with u and v swapped
	function automatic void queue_match(input logic [31:0] wx, input logic [31:0] wy,
			input logic [31:0] wz, input logic [15:0] mu, input logic [15:0] mv,
			input logic lastp);
		rig_in_t m;
		m.world_x    = wx;
		m.world_y    = wy;
		m.world_z    = wz;
		m.meas_u     = mu;
		m.meas_v     = mv;
		m.ref_u      = ~mv;
		m.ref_v      = ~mu;
		m.last_point = lastp;
		match_backlog.insert(match_backlog.size(), m);
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task automatic compare_field(input string field, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
				results_seen, field, got, want));
	endtask

	// Write one register and mirror it in the shadow copy
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_POSE_ROW0:   pose_rows[0] = val;
			CFG_POSE_ROW1:   pose_rows[1] = val;
			CFG_POSE_ROW2:   pose_rows[2] = val;
			CFG_FOCAL_X:     focal_u = val[15:0];
			CFG_FOCAL_Y:     focal_v = val[15:0];
			CFG_CENTER_X:    center_u = val[15:0];
			CFG_CENTER_Y:    center_v = val[15:0];
			CFG_ERROR_LIMIT: err_limit = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued request went in and every result came back
	task automatic settle();
		do
			@(posedge clk);
		while (match_backlog.size() != 0 || in_valid || pending_verdicts.size() != 0);
	endtask

	// Present requests from the backlog, with random gaps between them while idling is on
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// hold the request until it is taken
		end else if (send_gap != 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (drain_hold) begin
			in_valid <= 1'b0;
		end else if (match_backlog.size() != 0) begin
			in_data  <= match_backlog.pop_front();
			in_valid <= 1'b1;
			send_gap = idle_on ? $urandom_range(0, 11) : 0;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// After each result, stall the result side at random while idling is on
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_took)
				stall_left = idle_on ? $urandom_range(0, 11) : 0;
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check results against the oldest verdict, then predict newly taken requests
	always @(posedge clk) begin
		rig_out_t want;
		rig_out_t got;
		in_took  = arst_n && in_valid && in_ready;
		out_took = arst_n && out_valid && out_ready;
		if (out_took) begin
			got = out_data;
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no request waiting",
					results_seen));
			end else begin
				want = pending_verdicts.pop_front();
				compare_field("is_outlier", got.is_outlier, want.is_outlier);
				compare_field("depth_zero", got.depth_zero, want.depth_zero);
				compare_field("out_ref_u", got.out_ref_u, want.out_ref_u);
				compare_field("out_ref_v", got.out_ref_v, want.out_ref_v);
				compare_field("out_meas_u", got.out_meas_u, want.out_meas_u);
				compare_field("out_meas_v", got.out_meas_v, want.out_meas_v);
				compare_field("inliers_so_far", got.inliers_so_far, want.inliers_so_far);
				compare_field("outliers_so_far", got.outliers_so_far, want.outliers_so_far);
				compare_field("set_done", got.set_done, want.set_done);
			end
			// release the sender once everything outstanding has come back
			if (pending_verdicts.size() == 0)
				drain_hold = 1'b0;
		end
		if (in_took) begin
			pending_verdicts.insert(pending_verdicts.size(), gate_match(in_data));
			accepted_count++;
			// at the 500th request, and now and then at random, stop sending until the pipeline drains
			if (accepted_count == 500 || $urandom_range(0, 199) == 0)
				drain_hold = 1'b1;
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		rig_in_t m;
		longint  cx, cy, cz, pu, pv, span, jitter, fu, fv, cu, cv;
		pose_rows[0] = RST_POSE_ROW0;
		pose_rows[1] = RST_POSE_ROW1;
		pose_rows[2] = RST_POSE_ROW2;
		focal_u   = RST_FOCAL_X;
		focal_v   = RST_FOCAL_Y;
		center_u  = RST_CENTER_X;
		center_v  = RST_CENTER_Y;
		err_limit = RST_ERROR_LIMIT;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: zero point and field extremes, closing a set
		queue_match('0, '0, '0, 16'h0000, 16'h0000, 1'b0);
		queue_match(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_match(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'h0000, 1'b1);
		queue_match(Q16_ONE, -Q16_ONE, Q16_ONE * 3, 16'd8000, 16'd9000, 1'b0);
		settle();

		// Identity pose, 500 px focal, 2 px limit
		write_reg(CFG_POSE_ROW0, {16'h4000, 16'h0000, 16'h0000, 16'h0000});
		write_reg(CFG_POSE_ROW1, {16'h0000, 16'h4000, 16'h0000, 16'h0000});
		write_reg(CFG_POSE_ROW2, {16'h0000, 16'h0000, 16'h4000, 16'h0000});
		write_reg(CFG_FOCAL_X, 64'd8000);
		write_reg(CFG_FOCAL_Y, 64'd8000);
		write_reg(CFG_CENTER_X, 64'd5120);
		write_reg(CFG_CENTER_Y, 64'd5120);
		write_reg(CFG_ERROR_LIMIT, 64'd32);
		// on axis, error exactly at the limit, just over it
		queue_match('0, '0, Q16_ONE * 2, 16'd5120, 16'd5120, 1'b0);
		queue_match('0, '0, Q16_ONE * 2, 16'd5152, 16'd5120, 1'b0);
		queue_match('0, '0, Q16_ONE * 2, 16'd5153, 16'd5120, 1'b0);
		// zero depth, then points behind the camera
		queue_match('0, '0, '0, 16'd5120, 16'd5120, 1'b0);
		queue_match('0, '0, -Q16_ONE * 2, 16'd5120, 16'd5120, 1'b0);
		queue_match('0, '0, -Q16_ONE * 2, 16'd5220, 16'd5000, 1'b0);
		queue_match(Q16_ONE, -Q16_ONE, Q16_ONE * 4, 16'd7120, 16'd3120, 1'b1);
		settle();

		// Tiny depth scale and zero limit
		write_reg(CFG_POSE_ROW2, {16'h0000, 16'h0000, 16'h0001, 16'h0000});
		write_reg(CFG_ERROR_LIMIT, 64'd0);
		queue_match('0, '0, 32'sd1, 16'd5120, 16'd5120, 1'b0);
		queue_match(Q16_ONE, '0, 32'sd1, 16'd5120, 16'd5120, 1'b0);
		queue_match('0, '0, -32'sd1, 16'd5120, 16'd5120, 1'b0);
		queue_match('0, '0, -32'sd1, 16'd5121, 16'd5120, 1'b0);
		queue_match('0, '0, Q16_ONE, 16'd5121, 16'd5120, 1'b1);
		settle();

		// All-ones registers
		write_reg(CFG_POSE_ROW0, '1);
		write_reg(CFG_POSE_ROW1, '1);
		write_reg(CFG_POSE_ROW2, '1);
		write_reg(CFG_FOCAL_X, 64'hFFFF);
		write_reg(CFG_FOCAL_Y, 64'hFFFF);
		write_reg(CFG_CENTER_X, 64'hFFFF);
		write_reg(CFG_CENTER_Y, 64'hFFFF);
		write_reg(CFG_ERROR_LIMIT, 64'hFFFF);
		queue_match(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_match(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'h0000, 1'b0);
		queue_match('0, '0, '0, 16'hFFFF, 16'h0000, 1'b1);
		settle();

		// Largest positive and negative pose terms, zero camera
		write_reg(CFG_POSE_ROW0, 64'h7FFF_7FFF_7FFF_7FFF);
		write_reg(CFG_POSE_ROW1, 64'h8000_8000_8000_8000);
		write_reg(CFG_POSE_ROW2, 64'h8000_7FFF_8000_7FFF);
		write_reg(CFG_FOCAL_X, 64'd0);
		write_reg(CFG_FOCAL_Y, 64'd0);
		write_reg(CFG_CENTER_X, 64'd0);
		write_reg(CFG_CENTER_Y, 64'd0);
		write_reg(CFG_ERROR_LIMIT, 64'd0);
		queue_match(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1234, 16'hFEDC, 1'b0);
		queue_match(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h7FFF, 1'b0);
		queue_match(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0001, 16'h0001, 1'b0);
		settle();

		// Null pose: every depth is zero
		write_reg(CFG_POSE_ROW0, '0);
		write_reg(CFG_POSE_ROW1, '0);
		write_reg(CFG_POSE_ROW2, '0);
		queue_match(32'h1357_9BDF, 32'hECA8_6420, 32'h0F0F_0F0F, 16'h5A5A, 16'hA5A5, 1'b1);

		// Random chunks, each with its own camera; mostly aimed points, some noise
		for (int chunk = 0; chunk < 8; chunk++) begin
			settle();
			write_reg(CFG_POSE_ROW0, pose_row_rand(0));
			write_reg(CFG_POSE_ROW1, pose_row_rand(1));
			write_reg(CFG_POSE_ROW2, pose_row_rand(2));
			write_reg(CFG_FOCAL_X, 64'($urandom_range(3200, 32000)));
			write_reg(CFG_FOCAL_Y, 64'($urandom_range(3200, 32000)));
			write_reg(CFG_CENTER_X, 64'($urandom_range(1600, 16000)));
			write_reg(CFG_CENTER_Y, 64'($urandom_range(1600, 16000)));
			write_reg(CFG_ERROR_LIMIT, (chunk == 2) ? 64'd0 :
				(chunk == 6) ? 64'hFFFF : 64'($urandom_range(1, 320)));
			idle_on = (chunk != 3 && chunk != 6);
			for (int n = 0; n < 250; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					m.world_x    = $urandom;
					m.world_y    = $urandom;
					m.world_z    = $urandom;
					m.meas_u     = $urandom;
					m.meas_v     = $urandom;
					m.ref_u      = $urandom;
					m.ref_v      = $urandom;
					m.last_point = ($urandom_range(0, 7) == 0);
				end else begin
					m.world_x    = $urandom_range(0, 40 << 16) - (20 << 16);
					m.world_y    = $urandom_range(0, 40 << 16) - (20 << 16);
					m.world_z    = $urandom_range(1 << 16, 60 << 16);
					m.ref_u      = $urandom;
					m.ref_v      = $urandom;
					m.last_point = ($urandom_range(0, 24) == 0);
					cx = cam_exact(pose_rows[0], m) >>> 14;
					cy = cam_exact(pose_rows[1], m) >>> 14;
					cz = cam_exact(pose_rows[2], m) >>> 14;
					fu = focal_u;
					fv = focal_v;
					cu = center_u;
					cv = center_v;
					span = err_limit + (err_limit >> 1) + 2;
					if (cz > 0) begin
						// aim at the projection, then scatter around the limit
						jitter = $urandom_range(0, 2 * span);
						pu = cu + (fu * cx) / cz + jitter - span;
						jitter = $urandom_range(0, 2 * span);
						pv = cv + (fv * cy) / cz + jitter - span;
						if (pu < 0)
							pu = 0;
						else if (pu > 65535)
							pu = 65535;
						if (pv < 0)
							pv = 0;
						else if (pv > 65535)
							pv = 65535;
						m.meas_u = pu[15:0];
						m.meas_v = pv[15:0];
					end else begin
						m.meas_u = $urandom;
						m.meas_v = $urandom;
					end
				end
				match_backlog.insert(match_backlog.size(), m);
			end
		end
		settle();

		// Run one set back to back without idling: zero depths, then points on axis
		write_reg(CFG_POSE_ROW0, '0);
		write_reg(CFG_POSE_ROW1, '0);
		write_reg(CFG_POSE_ROW2, {16'h0000, 16'h0000, 16'h4000, 16'h0000});
		idle_on = 1'b0;
		for (int n = 0; n < 40; n++)
			queue_match('0, '0, (n < 20) ? 32'sd0 : Q16_ONE, center_u, center_v,
				n == 39);
		settle();

		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
sv/rig_pkg.sv
sv/rig_ctrl.sv
sv/rig_dp.sv
sv/reprojection_inlier_gate.sv
tb/tb_reprojection_inlier_gate.sv
